/* src/wdt_pkg.sv */
// Shared types and constants for the watchdog timer register block.
// Holds the transaction payload structs, state flag group and code enums.
// No dependencies.
package wdt_pkg;

    localparam int unsigned DATA_WIDTH          = 32;
    localparam int unsigned COUNT_WIDTH_DEFAULT = 32;
    localparam logic [31:0] RELOAD_RESET        = 32'h0000_ffff;
    localparam logic [31:0] FEED_KEY_RESET      = 32'h5a5a_5a5a;
    localparam logic [31:0] LOCK_KEY_RESET      = 32'ha5a5_a5a5;

    typedef enum logic [1:0] {
        FUNC_TICK  = 2'd0,
        FUNC_READ  = 2'd1,
        FUNC_WRITE = 2'd2
    } wdt_func_t;

    typedef enum logic [2:0] {
        REG_CTRL = 3'd0,
        REG_LOAD = 3'd1,
        REG_VAL  = 3'd2,
        REG_SR   = 3'd3,
        REG_KEY  = 3'd4
    } wdt_reg_t;

    typedef enum logic {
        CFG_FEED_KEY = 1'b0,
        CFG_LOCK_KEY = 1'b1
    } wdt_cfg_t;

    typedef struct packed {
        logic [1:0]            func;
        logic [2:0]            reg_index;
        logic [DATA_WIDTH-1:0] wdata;
    } wdt_in_t;

    typedef struct packed {
        logic [DATA_WIDTH-1:0] read_data;
        logic                  irq;
        logic                  access_error;
    } wdt_out_t;

    typedef struct packed {
        logic enable;
        logic irq_enable;
        logic reset_enable;
        logic armed;
        logic timeout;
        logic lock;
    } wdt_flags_t;

endpackage

/* src/wdt_step.sv */
// Next-state and result logic for one watchdog transaction.
// Depends on wdt_pkg.
module wdt_step #(
    parameter int unsigned COUNT_WIDTH = wdt_pkg::COUNT_WIDTH_DEFAULT
) (
    input  wdt_pkg::wdt_in_t          item,
    input  wdt_pkg::wdt_flags_t       flags_cur,
    input  logic [COUNT_WIDTH-1:0]    count_cur,
    input  logic [31:0]               reload_cur,
    input  logic [31:0]               feed_key,
    input  logic [31:0]               lock_key,
    output wdt_pkg::wdt_flags_t       flags_next,
    output logic [COUNT_WIDTH-1:0]    count_next,
    output logic [31:0]               reload_next,
    output wdt_pkg::wdt_out_t         result
);

    logic [COUNT_WIDTH-1:0] reload_cnt;
    logic                   reload_zero;
    logic [31:0]            rd;
    logic                   err;

    assign reload_zero = (reload_cur[COUNT_WIDTH-1:0] == '0);
    assign reload_cnt  = reload_zero ? COUNT_WIDTH'(1) : reload_cur[COUNT_WIDTH-1:0];

    always_comb begin
        flags_next  = flags_cur;
        count_next  = count_cur;
        reload_next = reload_cur;
        rd          = '0;
        err         = 1'b0;
        unique case (item.func)
            wdt_pkg::FUNC_TICK: begin
                if (flags_cur.enable && flags_cur.armed) begin
                    if (count_cur[COUNT_WIDTH-1:1] == '0) begin
                        count_next         = '0;
                        flags_next.timeout = 1'b1;
                        flags_next.armed   = 1'b0;
                    end else begin
                        count_next = count_cur - COUNT_WIDTH'(1);
                    end
                end
            end
            wdt_pkg::FUNC_READ: begin
                unique case (item.reg_index)
                    wdt_pkg::REG_CTRL: rd = {28'd0, flags_cur.lock, flags_cur.reset_enable,
                                             flags_cur.irq_enable, flags_cur.enable};
                    wdt_pkg::REG_LOAD: rd = reload_cur;
                    wdt_pkg::REG_VAL:  rd = 32'(count_cur);
                    wdt_pkg::REG_SR:   rd = {31'd0, flags_cur.timeout};
                    wdt_pkg::REG_KEY:  rd = '0;
                    default:           err = 1'b1;
                endcase
            end
            wdt_pkg::FUNC_WRITE: begin
                unique case (item.reg_index)
                    wdt_pkg::REG_CTRL: begin
                        if (flags_cur.lock) begin
                            err = 1'b1;
                        end else begin
                            flags_next.enable       = item.wdata[0];
                            flags_next.irq_enable   = item.wdata[1];
                            flags_next.reset_enable = item.wdata[2];
                            if (!flags_cur.enable && item.wdata[0]) begin
                                count_next         = reload_cnt;
                                flags_next.timeout = 1'b0;
                                flags_next.armed   = 1'b1;
                            end
                        end
                    end
                    wdt_pkg::REG_LOAD: begin
                        reload_next = item.wdata;
                        if (!flags_cur.enable) begin
                            count_next = item.wdata[COUNT_WIDTH-1:0];
                        end
                    end
                    wdt_pkg::REG_VAL: err = 1'b1;
                    wdt_pkg::REG_SR: begin
                        if (item.wdata[0]) begin
                            flags_next.timeout = 1'b0;
                        end
                    end
                    wdt_pkg::REG_KEY: begin
                        if (item.wdata == feed_key) begin
                            count_next         = reload_cnt;
                            flags_next.timeout = 1'b0;
                            flags_next.armed   = flags_cur.enable;
                        end else if (item.wdata == lock_key) begin
                            flags_next.lock = 1'b1;
                        end
                    end
                    default: err = 1'b1;
                endcase
            end
            default: begin
            end
        endcase
    end

    assign result.read_data    = rd;
    assign result.irq          = flags_next.timeout && flags_next.irq_enable;
    assign result.access_error = err;

endmodule

/* src/watchdog_timer_registers.sv */
// Watchdog timer register block: one tick, register read or register write per
// transaction. An accepted transaction is registered; once the output register is free
// or being read, it is applied to the timer state and its result is registered for
// m_data. Throughput is one transaction per clock, set by the single state update
// stage, as long as m_ready stays high. Keys are set over the cfg port.
// Depends on wdt_pkg and wdt_step.
module watchdog_timer_registers #(
    parameter int unsigned COUNT_WIDTH = wdt_pkg::COUNT_WIDTH_DEFAULT
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  wdt_pkg::wdt_in_t  s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output wdt_pkg::wdt_out_t m_data,
    input  logic              cfg_we,
    input  logic              cfg_index,
    input  logic [31:0]       cfg_wdata
);

    logic                   in_valid_reg;
    wdt_pkg::wdt_in_t       in_data_reg;
    logic                   out_valid_reg;
    wdt_pkg::wdt_out_t      out_data_reg;
    wdt_pkg::wdt_flags_t    flags_reg;
    wdt_pkg::wdt_flags_t    flags_next;
    logic [COUNT_WIDTH-1:0] count_reg;
    logic [COUNT_WIDTH-1:0] count_next;
    logic [31:0]            reload_reg;
    logic [31:0]            reload_next;
    logic [31:0]            feed_key_reg;
    logic [31:0]            lock_key_reg;
    wdt_pkg::wdt_out_t      result;
    logic                   advance;

    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;
    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

    wdt_step #(
        .COUNT_WIDTH(COUNT_WIDTH)
    ) u_step (
        .item       (in_data_reg),
        .flags_cur  (flags_reg),
        .count_cur  (count_reg),
        .reload_cur (reload_reg),
        .feed_key   (feed_key_reg),
        .lock_key   (lock_key_reg),
        .flags_next (flags_next),
        .count_next (count_next),
        .reload_next(reload_next),
        .result     (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            flags_reg     <= '0;
            count_reg     <= COUNT_WIDTH'(wdt_pkg::RELOAD_RESET);
            reload_reg    <= wdt_pkg::RELOAD_RESET;
            feed_key_reg  <= wdt_pkg::FEED_KEY_RESET;
            lock_key_reg  <= wdt_pkg::LOCK_KEY_RESET;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
                flags_reg     <= flags_next;
                count_reg     <= count_next;
                reload_reg    <= reload_next;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_we) begin
                unique case (cfg_index)
                    wdt_pkg::CFG_FEED_KEY: feed_key_reg <= cfg_wdata;
                    wdt_pkg::CFG_LOCK_KEY: lock_key_reg <= cfg_wdata;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_data_reg <= s_data;
        end
        if (advance) begin
            out_data_reg <= result;
        end
    end

    a_lock_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        flags_reg.lock |=> flags_reg.lock)
        else $error("lock flag cleared");

    a_timeout_at_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(flags_reg.timeout) |-> (count_reg == '0))
        else $error("timeout raised with nonzero count");

    a_irq_matches_state: assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> (out_data_reg.irq == (flags_reg.timeout && flags_reg.irq_enable)))
        else $error("irq result disagrees with state");

endmodule

/* sim/tb_top.sv */
`timescale 1ns / 100ps
// Self-checking testbench for the watchdog timer register block.
// Drives tick/read/write/idle transactions against a local watchdog model and checks
// every reply; depends on wdt_pkg and watchdog_timer_registers.
module tb_top;
    import wdt_pkg::*;

    localparam int unsigned COUNT_W     = COUNT_WIDTH_DEFAULT;
    localparam logic [31:0] CNT_MASK    = {32{1'b1}} >> (32 - COUNT_W);
    localparam logic [1:0]  FUNC_IDLE   = 2'd3;
    localparam int unsigned CYCLE_LIMIT = 200000;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    wdt_in_t     s_data = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    wdt_out_t    m_data;
    logic        cfg_we = 1'b0;
    logic        cfg_index = 1'b0;
    logic [31:0] cfg_wdata = '0;

    logic [31:0] feed_key_m;
    logic [31:0] lock_key_m;
    logic [31:0] load_m;
    logic [31:0] count_m;
    wdt_flags_t  flags;

    wdt_out_t    replies_due[$];
    bit          idle_on = 1'b1;
    int unsigned sent_cnt = 0;
    int unsigned checked_cnt = 0;
    int unsigned mismatches = 0;
    int unsigned timeouts_seen = 0;
    int unsigned access_errs = 0;
    int unsigned cycle_cnt = 0;
    int unsigned ready_gap = 0;

    watchdog_timer_registers #(.COUNT_WIDTH(COUNT_W)) dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always #2 aclk = ~aclk;

    function automatic void wdt_reload();
        count_m = ((load_m & CNT_MASK) != 0) ? (load_m & CNT_MASK) : 32'd1;
        flags.timeout = 1'b0;
        flags.armed = flags.enable;
    endfunction

    function automatic wdt_out_t wdt_apply(wdt_in_t t);
        wdt_out_t r;
        logic was_en;
        r = '0;
        case (t.func)
            FUNC_TICK: begin
                if (flags.enable && flags.armed) begin
                    if (count_m <= 32'd1) begin
                        count_m = '0;
                        flags.timeout = 1'b1;
                        flags.armed = 1'b0;
                        timeouts_seen++;
                    end else begin
                        count_m = count_m - 32'd1;
                    end
                end
            end
            FUNC_READ: begin
                case (t.reg_index)
                    REG_CTRL: r.read_data = {28'd0, flags.lock, flags.reset_enable,
                                             flags.irq_enable, flags.enable};
                    REG_LOAD: r.read_data = load_m;
                    REG_VAL:  r.read_data = count_m & CNT_MASK;
                    REG_SR:   r.read_data = {31'd0, flags.timeout};
                    REG_KEY:  r.read_data = '0;
                    default:  r.access_error = 1'b1;
                endcase
            end
            FUNC_WRITE: begin
                case (t.reg_index)
                    REG_CTRL: begin
                        if (flags.lock) begin
                            r.access_error = 1'b1;
                        end else begin
                            was_en = flags.enable;
                            flags.enable = t.wdata[0];
                            flags.irq_enable = t.wdata[1];
                            flags.reset_enable = t.wdata[2];
                            if (!was_en && flags.enable) wdt_reload();
                        end
                    end
                    REG_LOAD: begin
                        load_m = t.wdata;
                        if (!flags.enable) count_m = t.wdata & CNT_MASK;
                    end
                    REG_VAL: r.access_error = 1'b1;
                    REG_SR: begin
                        if (t.wdata[0]) flags.timeout = 1'b0;
                    end
                    REG_KEY: begin
                        if (t.wdata == feed_key_m) wdt_reload();
                        else if (t.wdata == lock_key_m) flags.lock = 1'b1;
                    end
                    default: r.access_error = 1'b1;
                endcase
            end
            default: ;
        endcase
        r.irq = flags.timeout && flags.irq_enable;
        return r;
    endfunction

    function automatic wdt_in_t bus_op(logic [1:0] f, logic [2:0] r, logic [31:0] d);
        wdt_in_t t;
        t.func = f;
        t.reg_index = r;
        t.wdata = d;
        return t;
    endfunction

    function automatic wdt_in_t random_item();
        wdt_in_t t;
        int unsigned pick;
        pick = $urandom_range(0, 99);
        t.reg_index = 3'($urandom_range(0, 7));
        t.wdata = $urandom;
        if (pick < 40) t.func = FUNC_TICK;
        else if (pick < 65) t.func = FUNC_READ;
        else if (pick < 97) t.func = FUNC_WRITE;
        else t.func = FUNC_IDLE;
        if (t.func == FUNC_WRITE && t.reg_index == REG_KEY && $urandom_range(0, 1) == 0)
            t.wdata = feed_key_m;
        if (t.func == FUNC_WRITE && t.reg_index == REG_LOAD && $urandom_range(0, 2) != 0)
            t.wdata = 32'($urandom_range(0, 16));
        return t;
    endfunction

    task automatic send_item(input wdt_in_t t);
        if (idle_on && $urandom_range(0, 4) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= t;
        do @(posedge aclk); while (!s_ready);
        replies_due.push_back(wdt_apply(t));
        sent_cnt++;
    endtask

    task automatic drain_replies();
        s_valid <= 1'b0;
        while (replies_due.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic load_key(input wdt_cfg_t which, input logic [31:0] value);
        drain_replies();
        cfg_we <= 1'b1;
        cfg_index <= which;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_we <= 1'b0;
        if (which == CFG_FEED_KEY) feed_key_m = value;
        else lock_key_m = value;
    endtask

    task automatic run_countdown();
        logic [31:0] span;
        int unsigned steps;
        span = ($urandom_range(0, 7) == 0) ? 32'd0 : 32'($urandom_range(1, 10));
        send_item(bus_op(FUNC_WRITE, REG_CTRL, $urandom & 32'hFFFF_FFFE));
        send_item(bus_op(FUNC_WRITE, REG_LOAD, span));
        send_item(bus_op(FUNC_WRITE, REG_CTRL, $urandom | 32'd1));
        steps = span + $urandom_range(0, 3);
        repeat (steps) begin
            if ($urandom_range(0, 5) == 0) send_item(random_item());
            else send_item(bus_op(FUNC_TICK, 3'($urandom_range(0, 7)), $urandom));
        end
        case ($urandom_range(0, 3))
            0: send_item(bus_op(FUNC_WRITE, REG_KEY, feed_key_m));
            1: send_item(bus_op(FUNC_WRITE, REG_SR, $urandom | 32'd1));
            2: send_item(bus_op(FUNC_READ, REG_SR, $urandom));
            default: send_item(bus_op(FUNC_READ, REG_VAL, $urandom));
        endcase
    endtask

    task automatic test_reset_readback();
        for (int i = 0; i < 8; i++) send_item(bus_op(FUNC_READ, 3'(i), 32'hFFFF_FFFF));
        send_item(bus_op(FUNC_IDLE, REG_CTRL, 32'hFFFF_FFFF));
        send_item(bus_op(FUNC_TICK, REG_VAL, '0));
    endtask

    task automatic test_register_corners();
        send_item(bus_op(FUNC_WRITE, REG_LOAD, 32'd0));
        send_item(bus_op(FUNC_READ, REG_VAL, '0));
        send_item(bus_op(FUNC_WRITE, REG_CTRL, 32'd3));
        send_item(bus_op(FUNC_TICK, REG_CTRL, '0));
        send_item(bus_op(FUNC_READ, REG_SR, '0));
        send_item(bus_op(FUNC_WRITE, REG_SR, 32'hFFFF_FFFE));
        send_item(bus_op(FUNC_WRITE, REG_SR, 32'd1));
        send_item(bus_op(FUNC_WRITE, REG_VAL, 32'hFFFF_FFFF));
        send_item(bus_op(FUNC_WRITE, REG_LOAD, 32'hFFFF_FFFF));
        send_item(bus_op(FUNC_WRITE, REG_KEY, feed_key_m));
        send_item(bus_op(FUNC_TICK, REG_CTRL, '0));
        send_item(bus_op(FUNC_WRITE, REG_KEY, 32'h1234_5678));
        send_item(bus_op(FUNC_WRITE, REG_CTRL, 32'd2));
        send_item(bus_op(FUNC_TICK, REG_CTRL, '0));
        send_item(bus_op(FUNC_READ, REG_VAL, '0));
        send_item(bus_op(FUNC_WRITE, REG_CTRL, 32'hFFFF_FFFF));
    endtask

    task automatic test_key_collision();
        load_key(CFG_FEED_KEY, 32'hFFFF_FFFF);
        load_key(CFG_LOCK_KEY, 32'hFFFF_FFFF);
        send_item(bus_op(FUNC_TICK, REG_CTRL, '0));
        send_item(bus_op(FUNC_WRITE, REG_KEY, 32'hFFFF_FFFF));
        send_item(bus_op(FUNC_READ, REG_CTRL, '0));
        send_item(bus_op(FUNC_WRITE, REG_CTRL, 32'd5));
    endtask

    task automatic test_countdown_traffic(input int unsigned quota, input bit allow_idle);
        int unsigned stop_at;
        stop_at = sent_cnt + quota;
        while (sent_cnt < stop_at) begin
            idle_on = allow_idle && ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 9) < 7) run_countdown();
            else repeat ($urandom_range(1, 4)) send_item(random_item());
        end
    endtask

    task automatic test_control_lock();
        load_key(CFG_LOCK_KEY, 32'd0);
        load_key(CFG_FEED_KEY, 32'hFFFF_FFFF);
        idle_on = 1'b0;
        run_countdown();
        send_item(bus_op(FUNC_WRITE, REG_KEY, 32'd0));
        send_item(bus_op(FUNC_READ, REG_CTRL, '0));
        send_item(bus_op(FUNC_WRITE, REG_CTRL, 32'd0));
        test_countdown_traffic(110, 1'b0);
    endtask

    always @(posedge aclk) begin
        if (ready_gap != 0) ready_gap--;
        else if (idle_on && $urandom_range(0, 5) == 0) ready_gap = $urandom_range(1, 3);
        m_ready <= (ready_gap == 0);
    end

    always @(posedge aclk) begin : check_replies
        wdt_out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (replies_due.size() == 0) begin
                $display("%0t: reply with none expected: read_data %h irq %b access_error %b",
                         $time, m_data.read_data, m_data.irq, m_data.access_error);
                mismatches++;
            end else begin
                want = replies_due.pop_front();
                checked_cnt++;
                if (want.access_error) access_errs++;
                if (m_data.read_data !== want.read_data || m_data.irq !== want.irq ||
                    m_data.access_error !== want.access_error) begin
                    $display("%0t: read_data exp %h got %h, irq exp %b got %b, %s %b got %b",
                             $time, want.read_data, m_data.read_data, want.irq, m_data.irq,
                             "access_error exp", want.access_error, m_data.access_error);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("no completion after %0d cycles, %0d replies outstanding",
                     cycle_cnt, replies_due.size());
            $display("watchdog_timer_registers verification failed");
            $finish;
        end
    end

    initial begin
        feed_key_m = FEED_KEY_RESET;
        lock_key_m = LOCK_KEY_RESET;
        load_m = RELOAD_RESET;
        count_m = RELOAD_RESET & CNT_MASK;
        flags = '0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_reset_readback();
        test_register_corners();
        test_key_collision();
        load_key(CFG_FEED_KEY, 32'd0);
        load_key(CFG_LOCK_KEY, $urandom | 32'h8000_0000);
        test_countdown_traffic(260, 1'b1);
        load_key(CFG_FEED_KEY, $urandom);
        load_key(CFG_LOCK_KEY, $urandom);
        test_countdown_traffic(250, 1'b1);
        test_control_lock();
        drain_replies();

        $display("%0d transactions sent, %0d replies checked", sent_cnt, checked_cnt);
        $display("%0d timeouts reached, %0d access errors, control locked in final phase",
                 timeouts_seen, access_errs);
        if (mismatches == 0 && replies_due.size() == 0) begin
            $display("watchdog_timer_registers verification clean");
        end else begin
            $display("watchdog_timer_registers verification failed");
        end
        $finish;
    end
endmodule

/* watchdog_timer_registers.f */
src/wdt_pkg.sv
src/wdt_step.sv
src/watchdog_timer_registers.sv
sim/tb_top.sv
